[rtl/core/assert_macros.svh]
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked on the next clock edge
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/ptpn_pkg.sv]
// Package: word types, constants and helpers for the polyline nearest-point block
package ptpn_pkg;
  localparam int NumPoints = 7;
  localparam int NumSegs = NumPoints - 1;
  localparam int CoordW = 20;
  localparam int DistW = 21;
  localparam int TW = 17;
  localparam int LabelW = 4;
  localparam int IdxW = 3;
  localparam int SegW = 3;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam logic [TW-1:0] TOne = 17'h10000;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_QUERY = 1'b1} cmd_t;

  typedef struct packed {
    logic cmd;
    logic [IdxW-1:0] point_index;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
  } in_word_t;

  typedef struct packed {
    logic [LabelW-1:0] segment_label;
    logic [DistW-1:0] distance;
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
    logic signed [CoordW-1:0] near_z;
    logic [TW-1:0] seg_param;
  } out_word_t;

  typedef struct packed {
    logic start_query;
    logic seg_load;
    logic [SegW-1:0] seg;
    logic last_seg;
  } cmd_bus_t;

  typedef struct packed {
    logic seg_done;
    logic query_done;
  } status_bus_t;

  function automatic logic [LabelW-1:0] seg_label(input logic [SegW-1:0] s);
    logic [LabelW-1:0] l;
    begin
      unique case (s)
        3'd0: l = 4'd2;
        3'd1: l = 4'd3;
        3'd2: l = 4'd4;
        3'd3: l = 4'd6;
        3'd4: l = 4'd7;
        3'd5: l = 4'd9;
        default: l = 4'd0;
      endcase
      return l;
    end
  endfunction
endpackage

[rtl/core/ptpn_ram.sv]
// Generic single-port-write RAM with registered read
module ptpn_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/ptpn_ctrl.sv]
// Controller: sequences segment loads and the query flow
module ptpn_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic query_go,
  input  ptpn_pkg::status_bus_t status,
  output ptpn_pkg::cmd_bus_t cmd,
  output logic busy
);
  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_FIN} state_t;
  state_t state;
  logic [ptpn_pkg::SegW-1:0] seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg <= '0;
      cmd <= '0;
      busy <= 1'b0;
    end else begin
      cmd.start_query <= 1'b0;
      cmd.seg_load <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (query_go) begin
            busy <= 1'b1;
            seg <= '0;
            cmd.start_query <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cmd.seg_load <= 1'b1;
          cmd.seg <= seg;
          cmd.last_seg <= (seg == ptpn_pkg::SegW'(ptpn_pkg::NumSegs - 1));
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (status.seg_done) begin
            if (seg == ptpn_pkg::SegW'(ptpn_pkg::NumSegs - 1)) begin
              state <= S_FIN;
            end else begin
              seg <= seg + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_FIN: begin
          if (status.query_done) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/ptpn_dp.sv]
// Datapath: point store, per-segment projection, divider, square root, best tracking
module ptpn_dp (
  input  logic clk,
  input  logic rst,
  input  logic load_we,
  input  logic query_we,
  input  logic [ptpn_pkg::IdxW-1:0] load_idx,
  input  ptpn_pkg::in_word_t in_word,
  input  ptpn_pkg::cmd_bus_t cmd,
  output ptpn_pkg::status_bus_t status,
  output logic res_valid,
  input  logic res_take,
  output ptpn_pkg::out_word_t res_word
);
  localparam int W = ptpn_pkg::CoordW;
  localparam int PW = 3 * W;
  localparam int DW = 21;
  localparam int MW = 42;
  localparam int SW = 47;

  typedef enum logic [3:0] {
    D_IDLE, D_RDA, D_RDB, D_DIFF, D_MUL, D_SUM, D_DIV, D_PROJ, D_RND, D_CD, D_CMP,
    D_SQRT, D_OUT
  } dstate_t;
  dstate_t st;

  logic [ptpn_pkg::IdxW-1:0] raddr;
  logic [PW-1:0] rdata_a, rdata_b;
  logic [ptpn_pkg::IdxW-1:0] rdaddr_b;

  ptpn_ram #(.Width(PW), .Depth(8)) u_ram_a (
    .clk(clk), .we(load_we), .waddr(load_idx),
    .wdata({in_word.px, in_word.py, in_word.pz}), .raddr(raddr), .rdata(rdata_a)
  );
  ptpn_ram #(.Width(PW), .Depth(8)) u_ram_b (
    .clk(clk), .we(load_we), .waddr(load_idx),
    .wdata({in_word.px, in_word.py, in_word.pz}), .raddr(rdaddr_b), .rdata(rdata_b)
  );
  assign rdaddr_b = raddr + 1'b1;

  logic signed [W-1:0] p [3];
  logic signed [W-1:0] a [3];
  logic signed [W-1:0] b [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] ua [3];
  logic signed [DW-1:0] ub [3];
  logic signed [MW-1:0] m_vu [3];
  logic signed [MW-1:0] m_vv [3];
  logic signed [MW-1:0] m_aa [3];
  logic signed [MW-1:0] m_bb [3];
  logic signed [SW-1:0] n_s, d_s, da2, db2;
  logic [1:0] k;
  localparam int SegW_l = ptpn_pkg::SegW;
  logic [SegW_l-1:0] seg;
  logic last;

  // divider: 16 quotient bits, one per cycle
  logic [SW:0] rem;
  logic [15:0] quo;
  logic [4:0] dcnt;
  logic interior;
  logic [ptpn_pkg::TW-1:0] tq;
  logic signed [DW+17:0] w;
  logic signed [W:0] c [3];
  logic signed [DW+1:0] dc;
  logic signed [MW+2:0] d2;
  logic [SW:0] best_d2;
  logic [ptpn_pkg::TW-1:0] best_t;
  logic signed [W-1:0] best_c [3];
  logic [SegW_l-1:0] best_seg;

  // square root: two radicand bits consumed per cycle
  logic [SW+1:0] sq_x;
  logic [SW+1:0] sq_r;
  logic [SW+1:0] sq_bit;
  logic [4:0] scnt;

  function automatic logic signed [W:0] rnd(input logic signed [DW+17:0] x);
    logic signed [DW+17:0] m;
    logic signed [DW+17:0] q;
    begin
      m = (x < 0) ? -x : x;
      q = (m + (DW+18)'(32768)) >>> 16;
      return (x < 0) ? -(W+1)'(q) : (W+1)'(q);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
      status <= '0;
      res_valid <= 1'b0;
      raddr <= '0;
    end else begin
      status <= '0;
      if (res_take) res_valid <= 1'b0;
      if (query_we) begin
        p[0] <= in_word.px; p[1] <= in_word.py; p[2] <= in_word.pz;
      end
      unique case (st)
        D_IDLE: begin
          if (cmd.start_query) begin
            best_d2 <= '1;
          end
          if (cmd.seg_load) begin
            raddr <= cmd.seg;
            seg <= cmd.seg;
            last <= cmd.last_seg;
            st <= D_RDA;
          end
        end
        D_RDA: st <= D_RDB;
        D_RDB: begin
          {a[0], a[1], a[2]} <= rdata_a;
          {b[0], b[1], b[2]} <= rdata_b;
          st <= D_DIFF;
        end
        D_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            v[i] <= DW'(b[i]) - DW'(a[i]);
            ua[i] <= DW'(a[i]) - DW'(p[i]);
            ub[i] <= DW'(b[i]) - DW'(p[i]);
          end
          st <= D_MUL;
        end
        D_MUL: begin
          for (int i = 0; i < 3; i++) begin
            m_vu[i] <= MW'(v[i]) * MW'(ua[i]);
            m_vv[i] <= MW'(v[i]) * MW'(v[i]);
            m_aa[i] <= MW'(ua[i]) * MW'(ua[i]);
            m_bb[i] <= MW'(ub[i]) * MW'(ub[i]);
          end
          st <= D_SUM;
        end
        D_SUM: begin
          n_s <= -(SW'(m_vu[0]) + SW'(m_vu[1]) + SW'(m_vu[2]));
          d_s <= SW'(m_vv[0]) + SW'(m_vv[1]) + SW'(m_vv[2]);
          da2 <= SW'(m_aa[0]) + SW'(m_aa[1]) + SW'(m_aa[2]);
          db2 <= SW'(m_bb[0]) + SW'(m_bb[1]) + SW'(m_bb[2]);
          rem <= '0;
          quo <= '0;
          dcnt <= '0;
          st <= D_DIV;
        end
        D_DIV: begin
          interior <= (d_s > 0) && (n_s > 0) && (n_s < d_s);
          if (dcnt == 5'd0) begin
            rem <= (SW+1)'(n_s);
            dcnt <= 5'd1;
          end else begin
            if ({rem[SW-1:0], 1'b0} >= (SW+1)'(d_s)) begin
              rem <= {rem[SW-1:0], 1'b0} - (SW+1)'(d_s);
              quo <= {quo[14:0], 1'b1};
            end else begin
              rem <= {rem[SW-1:0], 1'b0};
              quo <= {quo[14:0], 1'b0};
            end
            if (dcnt == 5'd16) st <= D_PROJ;
            dcnt <= dcnt + 1'b1;
          end
        end
        D_PROJ: begin
          if (interior) begin
            tq <= {1'b0, quo};
            k <= 2'd0;
            st <= D_RND;
          end else begin
            if (da2 < db2) begin
              tq <= '0;
              for (int i = 0; i < 3; i++) c[i] <= (W+1)'(a[i]);
            end else begin
              tq <= ptpn_pkg::TOne;
              for (int i = 0; i < 3; i++) c[i] <= (W+1)'(b[i]);
            end
            k <= 2'd0;
            st <= D_CD;
          end
        end
        D_RND: begin
          if (k != 2'd3) w <= (DW+18)'(v[k]) * (DW+18)'($signed({1'b0, tq}));
          if (k != 2'd0) c[k-1'b1] <= (W+1)'(a[k-1'b1]) + rnd(w);
          if (k == 2'd3) begin
            k <= 2'd0;
            st <= D_CD;
          end else begin
            k <= k + 1'b1;
          end
        end
        D_CD: begin
          if (k != 2'd3) dc <= (DW+2)'(p[k]) - (DW+2)'(c[k]);
          if (k == 2'd0) d2 <= '0;
          else d2 <= d2 + (MW+3)'(dc) * (MW+3)'(dc);
          if (k == 2'd3) st <= D_CMP;
          k <= k + 1'b1;
        end
        D_CMP: begin
          if ((SW+1)'(d2) < best_d2 || seg == '0) begin
            best_d2 <= (SW+1)'(d2);
            best_t <= tq;
            best_seg <= seg;
            for (int i = 0; i < 3; i++) best_c[i] <= W'(c[i]);
          end
          status.seg_done <= 1'b1;
          if (last) begin
            sq_x <= '0;
            sq_r <= '0;
            sq_bit <= (SW+2)'(1) << (SW+1 - ((SW+1) % 2));
            scnt <= '0;
            st <= D_SQRT;
          end else begin
            st <= D_IDLE;
          end
        end
        D_SQRT: begin
          if (scnt == 5'd0) begin
            sq_x <= (SW+2)'(best_d2);
            scnt <= 5'd1;
          end else if (sq_bit != '0) begin
            if (sq_x >= sq_r + sq_bit) begin
              sq_x <= sq_x - (sq_r + sq_bit);
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            st <= D_OUT;
          end
        end
        D_OUT: begin
          if (!res_valid || res_take) begin
            res_word.segment_label <= ptpn_pkg::seg_label(best_seg);
            res_word.distance <= (sq_r > (SW+2)'(ptpn_pkg::DistMax)) ?
                ptpn_pkg::DistMax : ptpn_pkg::DistW'(sq_r);
            res_word.near_x <= best_c[0];
            res_word.near_y <= best_c[1];
            res_word.near_z <= best_c[2];
            res_word.seg_param <= best_t;
            res_valid <= 1'b1;
            status.query_done <= 1'b1;
            st <= D_IDLE;
          end
        end
        default: st <= D_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/point_to_polyline_nearest.sv]
// Top level: nearest point on a seven-point polyline to a query point
//  channel | direction | handshake      | word
//  in      | input     | in_valid/stall | ptpn_pkg::in_word_t
//  out     | output    | out_valid/stall| ptpn_pkg::out_word_t
// A query runs the six segments in turn, endpoint or interior, each through the
// one-bit-a-cycle divider, then the two-bit-a-cycle square root. Reset is
// synchronous; the point store is not cleared.
// The input stalls while a query is in work; a waiting result holds
// until taken, while the next word may already be accepted.
module point_to_polyline_nearest (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ptpn_pkg::in_word_t in_word,
  output logic out_valid,
  input  logic out_stall,
  output ptpn_pkg::out_word_t out_word
);
  ptpn_pkg::cmd_bus_t cmd;
  ptpn_pkg::status_bus_t status;
  logic busy, acc, go;

  assign in_stall = busy;
  assign acc = in_valid && !busy;
  assign go = acc && (in_word.cmd == ptpn_pkg::CMD_QUERY);

  ptpn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .query_go(go), .status(status), .cmd(cmd), .busy(busy)
  );

  ptpn_dp u_dp (
    .clk(clk), .rst(rst),
    .load_we(acc && (in_word.cmd == ptpn_pkg::CMD_LOAD) && (in_word.point_index != 3'd7)),
    .query_we(go),
    .load_idx(in_word.point_index), .in_word(in_word), .cmd(cmd), .status(status),
    .res_valid(out_valid), .res_take(out_valid && !out_stall), .res_word(out_word)
  );
endmodule

[rtl/core/ptpn_checker.sv]
// Port checker for the polyline nearest-point block, bound to the top level
`include "assert_macros.svh"
module ptpn_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input ptpn_pkg::in_word_t in_word,
  input logic out_valid,
  input logic out_stall,
  input ptpn_pkg::out_word_t out_word
);
  logic out_wait;
  logic label_ok;
  logic query_acc;

  assign out_wait = out_valid && out_stall;
  assign label_ok = out_word.segment_label == 4'd2 || out_word.segment_label == 4'd3 ||
                    out_word.segment_label == 4'd4 || out_word.segment_label == 4'd6 ||
                    out_word.segment_label == 4'd7 || out_word.segment_label == 4'd9;
  assign query_acc = in_valid && !in_stall && (in_word.cmd == ptpn_pkg::CMD_QUERY);

  `CHK_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(out_word), "held word changed")
  `CHK_IMPL(a_label, clk, rst, out_valid, label_ok, "bad label")
  `CHK_IMPL(a_tparam, clk, rst, out_valid, out_word.seg_param <= 17'h10000, "t out of range")
  `CHK_NEXT(a_query_stall, clk, rst, query_acc, in_stall, "no stall after query")
endmodule

bind point_to_polyline_nearest ptpn_checker u_ptpn_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
